### hdl/pfc_pkg.sv
// ============================================================================
// pfc_pkg
// Shared types and constants for the palette frame compositor.
// ============================================================================
package pfc_pkg;

    localparam int MAX_WIDTH       = 512;
    localparam int MAX_HEIGHT      = 512;
    localparam int PALETTE_ENTRIES = 256;

    localparam int X_W          = $clog2(MAX_WIDTH);
    localparam int Y_W          = $clog2(MAX_HEIGHT);
    localparam int CANVAS_AW    = X_W + Y_W;
    localparam int CANVAS_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PAL_AW       = $clog2(PALETTE_ENTRIES);
    localparam int DIM_W        = 10;
    localparam int POS_W        = 9;
    localparam int RGB_W        = 24;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 10;

    localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_FRAME = 2'd1,
        OP_PIXEL = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CANVAS_WIDTH  = 3'd0,
        CFG_CANVAS_HEIGHT = 3'd1,
        CFG_BG_RED        = 3'd2,
        CFG_BG_GREEN      = 3'd3,
        CFG_BG_BLUE       = 3'd4
    } cfg_index_t;

    typedef struct packed {
        opcode_t          opcode;
        logic [7:0]       color_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [POS_W-1:0] x_pos;
        logic [POS_W-1:0] y_pos;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic             keep_previous;
        logic             transparent_enable;
        logic [7:0]       transparent_index;
    } pfc_in_t;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       out_of_range;
    } pfc_out_t;

    typedef struct packed {
        logic                 en;
        logic [CANVAS_AW-1:0] addr;
        logic [RGB_W-1:0]     data;
    } canvas_wr_t;

    typedef struct packed {
        logic                 en;
        logic [CANVAS_AW-1:0] addr;
    } canvas_rd_t;

endpackage

### hdl/palette_frame_compositor.sv
// ============================================================================
// palette_frame_compositor
// Composites palette-indexed frames onto an RGB canvas memory and serves
// canvas reads.
// ============================================================================
// Palette loads and pixels are taken whenever no sweep runs. A read result is
// registered in the canvas read register, then in the output register; a read
// is not taken while the last read is in flight or a result awaits out_ready. A
// read or frame start waits while a pixel's canvas write is pending. A clearing
// frame start sweeps all 262144 canvas entries, one entry per cycle, during
// which no item is taken. Reset clears control state; the canvas holds no
// defined data until the first frame start clears it.
module palette_frame_compositor
    import pfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pfc_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pfc_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [DIM_W-1:0]     canvas_width_reg, canvas_height_reg;
    logic [7:0]           bg_red_reg, bg_green_reg, bg_blue_reg;
    logic [POS_W-1:0]     rect_left_reg, rect_top_reg;
    logic [DIM_W-1:0]     rect_width_reg, rect_height_reg;
    logic [DIM_W-1:0]     col_reg, row_reg;
    logic                 trans_on_reg;
    logic [7:0]           trans_value_reg;
    logic                 first_frame_reg;
    logic [RGB_W-1:0]     pal_mem [PALETTE_ENTRIES];
    logic [RGB_W-1:0]     pal_rdata_reg;
    logic                 s1_pix_reg, s1_pix_next;
    logic [CANVAS_AW-1:0] s1_addr_reg;
    logic                 s1_black_reg;
    logic                 s1_read_reg;
    logic                 s1_oor_reg;
    logic                 out_valid_reg;
    pfc_out_t             out_data_reg;

    logic [DIM_W-1:0]     eff_w, eff_h;
    logic                 in_fire;
    logic                 busy;
    logic                 clear_start;
    logic [DIM_W:0]       pix_x, pix_y;
    logic                 pix_active;
    logic                 pix_in_canvas;
    logic                 pix_transparent;
    logic [DIM_W:0]       col_inc;
    logic                 rd_in_canvas;
    canvas_wr_t           wr;
    canvas_rd_t           rd;
    logic [RGB_W-1:0]     rd_data;

    assign eff_w = (canvas_width_reg > DIM_MAX_W) ? DIM_MAX_W : canvas_width_reg;
    assign eff_h = (canvas_height_reg > DIM_MAX_H) ? DIM_MAX_H : canvas_height_reg;

    always_comb
    begin
        case (in_data.opcode)
            OP_LOAD:  in_ready = !busy;
            OP_PIXEL: in_ready = !busy;
            OP_FRAME: in_ready = !busy && !s1_pix_reg;
            OP_READ:  in_ready = !busy && !s1_pix_reg && !s1_read_reg
                                 && (!out_valid_reg || out_ready);
            default:  in_ready = 1'b0;
        endcase
    end

    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= DIM_W'(512);
            canvas_height_reg <= DIM_W'(512);
            bg_red_reg        <= '0;
            bg_green_reg      <= '0;
            bg_blue_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[DIM_W-1:0];
                CFG_BG_RED:        bg_red_reg        <= cfg_data[7:0];
                CFG_BG_GREEN:      bg_green_reg      <= cfg_data[7:0];
                CFG_BG_BLUE:       bg_blue_reg       <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.opcode == OP_LOAD
            && 32'(in_data.color_index) < PALETTE_ENTRIES)
        begin
            pal_mem[in_data.color_index[PAL_AW-1:0]] <=
                {in_data.red, in_data.green, in_data.blue};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.opcode == OP_PIXEL)
        begin
            pal_rdata_reg <= pal_mem[in_data.color_index[PAL_AW-1:0]];
        end
    end

    assign pix_x = {2'b00, rect_left_reg} + {1'b0, col_reg};
    assign pix_y = {2'b00, rect_top_reg} + {1'b0, row_reg};
    assign pix_active = (rect_width_reg != '0) && (row_reg < rect_height_reg);
    assign pix_in_canvas = (pix_x < {1'b0, eff_w}) && (pix_y < {1'b0, eff_h});
    assign pix_transparent = trans_on_reg && (in_data.color_index == trans_value_reg);
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign s1_pix_next = in_fire && in_data.opcode == OP_PIXEL && pix_active
                         && pix_in_canvas && !pix_transparent;
    assign clear_start = in_fire && in_data.opcode == OP_FRAME
                         && (first_frame_reg || !in_data.keep_previous);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg   <= '0;
            rect_top_reg    <= '0;
            rect_width_reg  <= '0;
            rect_height_reg <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            trans_on_reg    <= 1'b0;
            trans_value_reg <= '0;
            first_frame_reg <= 1'b1;
        end
        else if (in_fire && in_data.opcode == OP_FRAME)
        begin
            rect_left_reg   <= in_data.x_pos;
            rect_top_reg    <= in_data.y_pos;
            rect_width_reg  <= in_data.frame_width;
            rect_height_reg <= in_data.frame_height;
            col_reg         <= '0;
            row_reg         <= '0;
            trans_on_reg    <= in_data.transparent_enable;
            trans_value_reg <= in_data.transparent_index;
            first_frame_reg <= 1'b0;
        end
        else if (in_fire && in_data.opcode == OP_PIXEL && pix_active)
        begin
            if (col_inc >= {1'b0, rect_width_reg})
            begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_inc[DIM_W-1:0];
            end
        end
    end

    assign rd_in_canvas = ({1'b0, in_data.x_pos} < eff_w) && ({1'b0, in_data.y_pos} < eff_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_pix_reg  <= 1'b0;
            s1_read_reg <= 1'b0;
        end
        else
        begin
            s1_pix_reg  <= s1_pix_next;
            s1_read_reg <= in_fire && in_data.opcode == OP_READ;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= {pix_y[Y_W-1:0], pix_x[X_W-1:0]};
        s1_black_reg <= !(32'(in_data.color_index) < PALETTE_ENTRIES);
        s1_oor_reg   <= !rd_in_canvas;
    end

    assign wr.en   = s1_pix_reg;
    assign wr.addr = s1_addr_reg;
    assign wr.data = s1_black_reg ? '0 : pal_rdata_reg;
    assign rd.en   = in_fire && in_data.opcode == OP_READ && rd_in_canvas;
    assign rd.addr = {in_data.y_pos[Y_W-1:0], in_data.x_pos[X_W-1:0]};

    pfc_canvas u_canvas (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (clear_start),
        .clear_color ({bg_red_reg, bg_green_reg, bg_blue_reg}),
        .wr          (wr),
        .rd          (rd),
        .rd_data     (rd_data),
        .busy        (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_read_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_read_reg)
        begin
            if (s1_oor_reg)
            begin
                out_data_reg <= '{pixel_red: 8'd0, pixel_green: 8'd0,
                                  pixel_blue: 8'd0, out_of_range: 1'b1};
            end
            else
            begin
                out_data_reg <= '{pixel_red: rd_data[23:16], pixel_green: rd_data[15:8],
                                  pixel_blue: rd_data[7:0], out_of_range: 1'b0};
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hdl/pfc_canvas.sv
// ============================================================================
// pfc_canvas
// Canvas memory with one write and one registered read port, and the
// sweep that fills the whole store with the background color.
// ============================================================================
module pfc_canvas
    import pfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear_start,
    input  logic [RGB_W-1:0]     clear_color,
    input  canvas_wr_t           wr,
    input  canvas_rd_t           rd,
    output logic [RGB_W-1:0]     rd_data,
    output logic                 busy
);

    typedef enum logic [1:0] {
        SWEEP_IDLE = 2'b01,
        SWEEP_RUN  = 2'b10
    } sweep_state_t;

    localparam logic [CANVAS_AW-1:0] LAST_ADDR = CANVAS_AW'(CANVAS_DEPTH - 1);

    logic [RGB_W-1:0]     canvas_mem [CANVAS_DEPTH];
    sweep_state_t         state_reg, state_next;
    logic [CANVAS_AW-1:0] sweep_addr_reg, sweep_addr_next;
    logic [RGB_W-1:0]     color_reg, color_next;
    logic [RGB_W-1:0]     rd_data_reg;
    logic                 mem_we;
    logic [CANVAS_AW-1:0] mem_waddr;
    logic [RGB_W-1:0]     mem_wdata;

    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        color_next      = color_reg;
        case (state_reg)
            SWEEP_IDLE:
            begin
                if (clear_start)
                begin
                    state_next      = SWEEP_RUN;
                    sweep_addr_next = '0;
                    color_next      = clear_color;
                end
            end
            SWEEP_RUN:
            begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == LAST_ADDR)
                begin
                    state_next = SWEEP_IDLE;
                end
            end
            default:
            begin
                state_next = SWEEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SWEEP_IDLE;
            sweep_addr_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
    end

    always_comb
    begin
        if (state_reg == SWEEP_RUN)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = color_reg;
        end
        else
        begin
            mem_we    = wr.en;
            mem_waddr = wr.addr;
            mem_wdata = wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            canvas_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= canvas_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = (state_reg == SWEEP_RUN);

endmodule
